// ----- rtl/core/assert_macros.svh -----
// concurrent assertion macros for the rotate-xor hash rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RXFH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RXFH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RXFH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define RXFH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rxfh_pkg.sv -----
// types, constants and helpers shared by the rotate-xor hash rtl
package rxfh_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PEND_W = 24;
	localparam int unsigned ROT_BACK = 31;

	localparam logic [1:0] POS_FULL = 2'd3;
	localparam logic [1:0] WIDX_SKIP = 2'd1;
	localparam logic [1:0] WIDX_MAX = 2'd2;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PEND_W-1:0] pend_t;

	typedef struct packed {
		byte_t data_byte;
		logic  has_byte;
		logic  end_of_message;
	} in_item_t;

	typedef struct packed {
		hash_t      hash;
		pend_t      pending;
		logic [1:0] pos;
	} acc_view_t;

	function automatic hash_t rotl1(input hash_t h);
		return (h << 1) | (h >> ROT_BACK);
	endfunction

	function automatic hash_t sext_byte(input byte_t b);
		return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

endpackage

// ----- rtl/core/rxfh_byte_if.sv -----
// valid/ready channel carrying one message byte item
interface rxfh_byte_if import rxfh_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  has_byte;
	logic  end_of_message;

	modport source(output valid, output data_byte, output has_byte, output end_of_message,
		input ready);
	modport sink(input valid, input data_byte, input has_byte, input end_of_message,
		output ready);
endinterface

// ----- rtl/core/rxfh_hash_if.sv -----
// valid/ready channel carrying one finished hash
interface rxfh_hash_if import rxfh_pkg::*; ();
	logic  valid;
	logic  ready;
	hash_t hash_value;

	modport source(output valid, output hash_value, input ready);
	modport sink(input valid, input hash_value, output ready);
endinterface

// ----- rtl/core/rotate_xor_file_hash.sv -----
// rotate-xor message hash, one byte item per transfer
// the closing item is first registered in item_s1, then its hash is registered in hash_q and shown on hash_out
// the closing item stays in item_s1 while an earlier finished hash on hash_out waits to be taken
// throughput: one item per cycle, stalled only while a finished hash waits and the next end is held
// reset: arst_n clears the running hash, the byte gather state and both valid flags at once
module rotate_xor_file_hash import rxfh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	rxfh_byte_if.sink       byte_in,
	rxfh_hash_if.source     hash_out
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      out_free;
	logic      adv_s1;
	logic      load_out;
	acc_view_t view;
	hash_t     tail_hash;
	hash_t     hash_q;
	logic      out_valid_q;

	assign out_free = !out_valid_q || hash_out.ready;
	assign adv_s1 = valid_s1 && (!item_s1.end_of_message || out_free);
	assign load_out = adv_s1 && item_s1.end_of_message;
	assign byte_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			item_s1 <= '{data_byte: byte_in.data_byte, has_byte: byte_in.has_byte,
				end_of_message: byte_in.end_of_message};
		end
	end

	rxfh_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.view   (view)
	);

	rxfh_tail u_tail (
		.view       (view),
		.hash_value (tail_hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (hash_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hash_q <= tail_hash;
		end
	end

	assign hash_out.valid = out_valid_q;
	assign hash_out.hash_value = hash_q;

	`RXFH_ASSERT_IMP(a_stall_cause, clk, arst_n, !byte_in.ready, valid_s1 && item_s1.end_of_message && out_valid_q && !hash_out.ready, "input stalled without a blocked result")
	`RXFH_ASSERT_NXT(a_end_gives_result, clk, arst_n, valid_s1 && item_s1.end_of_message && out_free, hash_out.valid, "closing item produced no result")
	`RXFH_ASSERT_NXT(a_end_held, clk, arst_n, valid_s1 && item_s1.end_of_message && !out_free, valid_s1 && item_s1.end_of_message, "blocked closing item lost")

endmodule

// ----- rtl/core/rxfh_accum.sv -----
// running hash state: word gathering and per-word rotate-xor, with the second word of a message skipped
`include "assert_macros.svh"

module rxfh_accum import rxfh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output acc_view_t view
);

	hash_t      hash_q;
	pend_t      pend_q;
	logic [1:0] pos_q;
	logic [1:0] widx_q;

	logic       word_done;
	hash_t      hash_d;
	pend_t      pend_d;
	logic [1:0] pos_d;
	logic [1:0] widx_d;

	always_comb begin
		word_done = item.has_byte && (pos_q == POS_FULL);
		hash_d = hash_q;
		pend_d = pend_q;
		pos_d = pos_q;
		widx_d = widx_q;
		if (word_done) begin
			if (widx_q != WIDX_SKIP) begin
				hash_d = rotl1(hash_q ^ {item.data_byte, pend_q});
			end
			if (widx_q != WIDX_MAX) begin
				widx_d = widx_q + 2'd1;
			end
			pend_d = '0;
			pos_d = '0;
		end else if (item.has_byte) begin
			case (pos_q)
				2'd0: pend_d[7:0] = item.data_byte;
				2'd1: pend_d[15:8] = item.data_byte;
				2'd2: pend_d[23:16] = item.data_byte;
				default: pend_d = pend_q;
			endcase
			pos_d = pos_q + 2'd1;
		end
	end

	assign view = '{hash: hash_d, pending: pend_d, pos: pos_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pend_q <= '0;
			pos_q <= '0;
			widx_q <= '0;
		end else if (step) begin
			if (item.end_of_message) begin
				hash_q <= '0;
				pend_q <= '0;
				pos_q <= '0;
				widx_q <= '0;
			end else begin
				hash_q <= hash_d;
				pend_q <= pend_d;
				pos_q <= pos_d;
				widx_q <= widx_d;
			end
		end
	end

	`RXFH_ASSERT_IMP(a_widx_range, clk, arst_n, 1'b1, widx_q <= WIDX_MAX, "word index out of range")
	`RXFH_ASSERT_NXT(a_clear_on_end, clk, arst_n, step && item.end_of_message, (hash_q == '0) && (pend_q == '0) && (pos_q == '0) && (widx_q == '0), "state not cleared after message end")
	`RXFH_ASSERT_IMP(a_empty_pending, clk, arst_n, pos_q == '0, pend_q == '0, "stale pending bytes with no byte held")

endmodule

// ----- rtl/core/rxfh_tail.sv -----
// folds the 0 to 3 leftover bytes into the hash at message end
module rxfh_tail import rxfh_pkg::*; (
	input  acc_view_t view,
	output hash_t     hash_value
);

	always_comb begin
		hash_t h;
		h = view.hash;
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < view.pos) begin
				h = rotl1(h ^ sext_byte(view.pending[k*BYTE_W +: BYTE_W]));
			end
		end
		hash_value = h;
	end

endmodule
